// ===== rtl/nls_pkg.sv =====
// ============================================================================
// nls_pkg: shared types and helpers for the number literal scanner
// Holds the byte class record, the queued beat, the scan phases, the
// phase transition table and the saturating length arithmetic.
// ============================================================================
package nls_pkg;

  // Width of the internal length counter and of the reported length.
  localparam int LENGTH_BITS = 16;
  localparam int TOKEN_W     = 16;
  localparam int WIDE_W      = (LENGTH_BITS > TOKEN_W) ? LENGTH_BITS : TOKEN_W;

  // Depth of the queue between the classifier and the scanner.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Character codes the classifier looks for.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Class flags of one text byte.
  typedef struct packed {
    logic dig;
    logic alp;
    logic hx;
    logic us;
    logic dot;
    logic zero;
    logic x;
    logic bo;
    logic p;
    logic e;
    logic sign;
  } char_class_t;

  // One classified beat as it travels through the queue.
  typedef struct packed {
    char_class_t cls;
    logic        first;
    logic        last;
  } beat_t;

  // Scan phases.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ZERO     = 4'd1,
    PH_HEX_INT  = 4'd2,
    PH_HEX_FRAC = 4'd3,
    PH_EXP_SIGN = 4'd4,
    PH_EXP_DIG  = 4'd5,
    PH_RADIX    = 4'd6,
    PH_DEC_INT  = 4'd7,
    PH_DOT      = 4'd8,
    PH_DEC_FRAC = 4'd9,
    PH_SUFFIX   = 4'd10,
    PH_REJECT   = 4'd15
  } phase_t;

  // Phase after taking a byte of class c in phase ph; PH_REJECT if not taken.
  function automatic phase_t next_phase(phase_t ph, char_class_t c);
    phase_t nx;
    nx = PH_REJECT;
    case (ph)
      PH_HEX_INT: begin
        if (c.hx || c.us)      nx = PH_HEX_INT;
        else if (c.dot)        nx = PH_HEX_FRAC;
        else if (c.p)          nx = PH_EXP_SIGN;
        else if (c.alp)        nx = PH_SUFFIX;
      end
      PH_HEX_FRAC: begin
        if (c.hx || c.us)      nx = PH_HEX_FRAC;
        else if (c.p)          nx = PH_EXP_SIGN;
        else if (c.alp)        nx = PH_SUFFIX;
      end
      PH_EXP_SIGN: begin
        if (c.sign || c.dig || c.us) nx = PH_EXP_DIG;
        else if (c.alp)              nx = PH_SUFFIX;
      end
      PH_EXP_DIG, PH_RADIX: begin
        if (c.dig || c.us)     nx = ph;
        else if (c.alp)        nx = PH_SUFFIX;
      end
      PH_DEC_INT: begin
        if (c.dig || c.us)     nx = PH_DEC_INT;
        else if (c.dot)        nx = PH_DOT;
        else if (c.e)          nx = PH_EXP_SIGN;
        else if (c.alp)        nx = PH_SUFFIX;
      end
      PH_DOT: begin
        if (c.dig)             nx = PH_DEC_FRAC;
      end
      PH_DEC_FRAC: begin
        if (c.dig || c.us)     nx = PH_DEC_FRAC;
        else if (c.e)          nx = PH_EXP_SIGN;
        else if (c.alp)        nx = PH_SUFFIX;
      end
      PH_SUFFIX: begin
        if (c.alp || c.us)     nx = PH_SUFFIX;
      end
      default: nx = PH_REJECT;
    endcase
    return nx;
  endfunction

  // Add one or two to the length, sticking at the all-ones value.
  function automatic logic [LENGTH_BITS-1:0] sat_add(logic [LENGTH_BITS-1:0] a,
                                                     logic [1:0] k);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(k);
    return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
  endfunction

  // Clamp the internal length to the width of the reported length.
  function automatic logic [TOKEN_W-1:0] clamp_len(logic [LENGTH_BITS-1:0] a);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(a);
    return (w > WIDE_W'({TOKEN_W{1'b1}})) ? '1 : w[TOKEN_W-1:0];
  endfunction

endpackage

// ===== rtl/nls_front.sv =====
// ============================================================================
// nls_front: byte classifier
// Turns each incoming text byte into the class flags the scanner needs,
// so the queue and the scanner never look at the raw byte.
// ============================================================================
module nls_front (
  input  logic [7:0]    char_byte,
  input  logic          first_char,
  input  logic          last_char,
  output nls_pkg::beat_t beat
);
  import nls_pkg::*;

  char_class_t cls;
  logic        lower;
  logic        upper;

  // Letter and digit ranges; bytes above 127 fall in none of them.
  assign lower = (char_byte >= CH_LA) && (char_byte <= CH_LZ);
  assign upper = (char_byte >= CH_UA) && (char_byte <= CH_UZ);

  // Class flags of the byte.
  always_comb begin
    cls.dig  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    cls.alp  = lower || upper;
    cls.hx   = cls.dig || ((char_byte >= CH_LA) && (char_byte <= CH_LF))
                       || ((char_byte >= CH_UA) && (char_byte <= CH_UF));
    cls.us   = (char_byte == CH_USCR);
    cls.dot  = (char_byte == CH_DOT);
    cls.zero = (char_byte == CH_ZERO);
    cls.x    = (char_byte == CH_LX) || (char_byte == CH_UX);
    cls.bo   = (char_byte == CH_LB) || (char_byte == CH_UB)
            || (char_byte == CH_LO) || (char_byte == CH_UO);
    cls.p    = (char_byte == CH_LP) || (char_byte == CH_UP);
    cls.e    = (char_byte == CH_LE) || (char_byte == CH_UE);
    cls.sign = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
  end

  assign beat = '{cls: cls, first: first_char, last: last_char};

endmodule

// ===== rtl/nls_fifo.sv =====
// ============================================================================
// nls_fifo: classified beat queue
// A short first-in first-out queue that lets the classifier keep taking
// bytes while the scanner waits on its output.
// ============================================================================
module nls_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nls_pkg::beat_t push_beat,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output nls_pkg::beat_t pop_beat
);
  import nls_pkg::*;

  beat_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign not_full  = (fill != (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_beat  = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/nls_back.sv =====
// ============================================================================
// nls_back: literal scanner
// Walks the scan phase machine over the classified beats, counts the bytes
// taken and registers one result when the literal ends.
// ============================================================================
module nls_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  nls_pkg::beat_t              q_beat,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nls_pkg::TOKEN_W-1:0] token_length,
  output logic                        hit_text_end
);
  import nls_pkg::*;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_next;

  logic                   active;
  logic                   direct;
  phase_t                 direct_ph;
  phase_t                 ph_eff;
  phase_t                 nx;
  logic [LENGTH_BITS-1:0] base;
  logic [LENGTH_BITS-1:0] sum;
  logic                   emit;
  logic                   emit_end;
  logic [LENGTH_BITS-1:0] emit_len;

  // A beat is taken whenever the output register is free or draining.
  assign q_pop = q_valid && (!out_valid || out_ready);

  // Decode of the current beat against the open scan.
  always_comb begin
    active    = q_beat.first || (phase != PH_IDLE);
    base      = q_beat.first ? '0 : count;
    direct    = 1'b0;
    direct_ph = PH_ZERO;
    if (q_beat.first) begin
      direct    = q_beat.cls.zero;
      direct_ph = PH_ZERO;
    end else if (phase == PH_ZERO) begin
      direct    = q_beat.cls.x || q_beat.cls.bo;
      direct_ph = q_beat.cls.x ? PH_HEX_INT : PH_RADIX;
    end
    ph_eff = (q_beat.first || (phase == PH_ZERO)) ? PH_DEC_INT : phase;
    nx     = next_phase(ph_eff, q_beat.cls);
    // A held dot is counted together with the digit that confirms it.
    sum    = sat_add(base, (!direct && (ph_eff == PH_DOT)) ? 2'd2 : 2'd1);
  end

  // Next scan phase and length.
  always_comb begin
    phase_next = phase;
    count_next = count;
    if (q_pop && active) begin
      if (direct) begin
        phase_next = direct_ph;
        count_next = sum;
      end else if (nx == PH_DOT) begin
        phase_next = PH_DOT;
        count_next = base;
      end else begin
        phase_next = nx;
        count_next = sum;
      end
      if (emit) begin
        phase_next = PH_IDLE;
        count_next = '0;
      end
    end
  end

  // Result of the current beat, if it closes the scan.
  always_comb begin
    emit     = 1'b0;
    emit_end = 1'b0;
    emit_len = sum;
    if (q_pop && active) begin
      if (direct) begin
        emit     = q_beat.last;
        emit_end = 1'b1;
      end else if (nx == PH_REJECT) begin
        emit     = 1'b1;
        emit_len = base;
      end else if (nx == PH_DOT) begin
        // A dot at text end is dropped and the scan closes before it.
        emit     = q_beat.last;
        emit_len = base;
      end else begin
        emit     = q_beat.last;
        emit_end = 1'b1;
      end
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      token_length <= clamp_len(emit_len);
      hit_text_end <= emit_end;
    end
  end

endmodule

// ===== rtl/number_literal_scanner.sv =====
// ============================================================================
// number_literal_scanner: numeric literal end finder
// A closing byte beat is stored in the queue, then its result is registered.
// Throughput: one byte beat per cycle while the queue is not full; the
// scanner phase machine takes one queued beat each cycle while its output
// register is free or draining.
// Reset: synchronous; clears the queue, closes any open scan and drops a
// pending result. No clearing pass is needed.
// ============================================================================
module number_literal_scanner (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  char_byte,
  input  logic                        first_char,
  input  logic                        last_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nls_pkg::TOKEN_W-1:0] token_length,
  output logic                        hit_text_end
);
  import nls_pkg::*;

  beat_t in_beat;
  beat_t q_beat;
  logic  q_valid;
  logic  q_pop;

  // Classify the incoming byte.
  nls_front u_front (
    .char_byte  (char_byte),
    .first_char (first_char),
    .last_char  (last_char),
    .beat       (in_beat)
  );

  // Queue between classifier and scanner.
  nls_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_beat (in_beat),
    .not_full  (in_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_beat  (q_beat)
  );

  // Scan phase machine and result register.
  nls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_beat       (q_beat),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_length (token_length),
    .hit_text_end (hit_text_end)
  );

endmodule

// ===== rtl/nls_checker.sv =====
// ============================================================================
// nls_checker: port-level checks for the number literal scanner
// Watches the top-level ports for reset behavior and result consistency.
// ============================================================================
module nls_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [nls_pkg::TOKEN_W-1:0] token_length,
  input logic                        hit_text_end
);
  import nls_pkg::*;

  // Reset drops any pending result.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present right after reset");

  // Reset empties the queue, so input is taken right away.
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // A scan that hits text end has always taken at least one byte.
  a_end_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit_text_end) |-> (token_length != '0))
    else $error("text-end result with zero length");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(token_length) && $stable(hit_text_end)))
    else $error("stalled result beat changed");

endmodule

bind number_literal_scanner nls_checker u_nls_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .token_length (token_length),
  .hit_text_end (hit_text_end)
);
